// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define PTOM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, also active during reset
`define PTOM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ptom_pkg.sv =====
// ----------------------------------------------------------------------------
// ptom_pkg
// Shared types and constants of the price-time order matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptom_pkg;

  localparam int DEF_SYMBOLS    = 8;
  localparam int DEF_BOOK_DEPTH = 16;
  localparam int SYM_BITS       = 3;
  localparam int PRICE_BITS     = 24;
  localparam int QTY_BITS       = 20;
  localparam int ARRIVAL_BITS   = 32;

  typedef enum logic [1:0] {
    KIND_FILL = 2'd0,
    KIND_REST = 2'd1,
    KIND_DONE = 2'd2,
    KIND_DROP = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic                  side_is_buy;
    logic [SYM_BITS-1:0]   symbol_index;
    logic [PRICE_BITS-1:0] limit_price;
    logic [QTY_BITS-1:0]   order_qty;
  } order_t;

  typedef struct packed {
    event_kind_t           event_kind;
    logic [SYM_BITS-1:0]   trade_symbol;
    logic [PRICE_BITS-1:0] trade_price;
    logic [QTY_BITS-1:0]   trade_qty;
    logic [QTY_BITS-1:0]   left_qty;
    logic                  last_of_run;
  } result_t;

endpackage

// ===== src/price_time_order_matcher.sv =====
// Each match pass reads (S_RD) and compares (S_CMP) each slot of the
// opposite book, then fills in S_FILL; resting scans the own book one slot
// per cycle while the result register is free; a zero-quantity order goes
// straight to S_CLOSE. One order at a time: a fill leads to a new scan, or to
// S_CLOSE when filled, else one empty scan plus up to BOOK_DEPTH slots to
// rest or drop. Reset clears all valid bits and the counter at once, no sweep.
// ----------------------------------------------------------------------------
// price_time_order_matcher
// Limit order matcher with per-symbol buy and sell books, price-time priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module price_time_order_matcher #(
  parameter int SYMBOLS    = ptom_pkg::DEF_SYMBOLS,
  parameter int BOOK_DEPTH = ptom_pkg::DEF_BOOK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              order_valid,
  output logic              order_ready,
  input  ptom_pkg::order_t  order,
  output logic              result_valid,
  input  logic              result_ready,
  output ptom_pkg::result_t result
);
  import ptom_pkg::*;

  localparam int ENTRIES   = SYMBOLS * 2 * BOOK_DEPTH;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int SLOT_W    = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BOOK_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_FILL  = 6'b001000,
    S_REST  = 6'b010000,
    S_CLOSE = 6'b100000
  } state_t;

  state_t                  state;
  logic                    is_buy;
  logic [SYM_BITS-1:0]     sym_in;
  logic [PRICE_BITS-1:0]   limit;
  logic [QTY_BITS-1:0]     left;
  logic [ARRIVAL_BITS-1:0] stamp;
  logic [ARRIVAL_BITS-1:0] arrival_counter;
  logic [ADDR_W-1:0]       opp_base;
  logic [ADDR_W-1:0]       own_base;
  logic [SLOT_W-1:0]       slot;
  logic                    found;
  logic [SLOT_W-1:0]       best_slot;
  logic [PRICE_BITS-1:0]   best_price;
  logic [ARRIVAL_BITS-1:0] best_arr;
  logic [QTY_BITS-1:0]     best_qty;
  logic [ENTRIES-1:0]      valid;

  // entry memories
  logic [PRICE_BITS-1:0]   price_mem [ENTRIES];
  logic [QTY_BITS-1:0]     qty_mem   [ENTRIES];
  logic [ARRIVAL_BITS-1:0] arr_mem   [ENTRIES];
  logic [PRICE_BITS-1:0]   rd_price;
  logic [QTY_BITS-1:0]     rd_qty;
  logic [ARRIVAL_BITS-1:0] rd_arr;

  logic                    accept;
  logic                    out_free;
  logic                    emit;
  logic [SYM_BITS-1:0]     sym_wrap;
  logic [ADDR_W-1:0]       base_buy;
  logic [ADDR_W-1:0]       base_sell;
  logic [ADDR_W-1:0]       addr;
  logic                    we_all;
  logic                    we_qty;
  logic [QTY_BITS-1:0]     wr_qty;
  logic [QTY_BITS-1:0]     fill;
  logic [QTY_BITS-1:0]     rest_qty;
  logic [QTY_BITS-1:0]     left_next;
  logic                    eligible;
  logic                    better;
  logic                    free_hit;

  assign order_ready = (state == S_IDLE);
  assign accept      = order_valid && order_ready;
  assign out_free    = !result_valid || result_ready;

  // symbol wrap to the configured number of books
  always_comb begin
    sym_wrap = order.symbol_index;
    for (int i = 0; i < 8; i++) begin
      if (32'(sym_wrap) >= SYMBOLS) sym_wrap = sym_wrap - SYM_BITS'(SYMBOLS);
    end
    base_buy  = ADDR_W'((32'(sym_wrap) * 2 + 1) * BOOK_DEPTH);
    base_sell = ADDR_W'((32'(sym_wrap) * 2) * BOOK_DEPTH);
  end

  // memory address select
  always_comb begin
    case (state)
      S_FILL:  addr = opp_base + ADDR_W'(best_slot);
      S_REST:  addr = own_base + ADDR_W'(slot);
      default: addr = opp_base + ADDR_W'(slot);
    endcase
  end

  // fill arithmetic
  always_comb begin
    fill      = (best_qty < left) ? best_qty : left;
    rest_qty  = best_qty - fill;
    left_next = left - fill;
  end

  // candidate compare for the scan
  always_comb begin
    eligible = valid[addr] && (is_buy ? (rd_price <= limit) : (rd_price >= limit));
    if (!found) begin
      better = 1'b1;
    end else if (rd_price != best_price) begin
      better = is_buy ? (rd_price < best_price) : (rd_price > best_price);
    end else begin
      better = rd_arr < best_arr;
    end
  end

  assign free_hit = (state == S_REST) && !valid[addr];
  assign we_all   = free_hit && out_free;
  assign we_qty   = ((state == S_FILL) && out_free) || we_all;
  assign wr_qty   = (state == S_FILL) ? rest_qty : left;

  // a result is loaded this cycle
  assign emit = out_free && ((state == S_FILL) || (state == S_CLOSE) ||
                ((state == S_REST) && (free_hit || slot == LAST_SLOT)));

  // entry memory write and registered read
  always_ff @(posedge clk) begin
    if (we_all) begin
      price_mem[addr] <= limit;
      arr_mem[addr]   <= stamp;
    end
    if (we_qty) qty_mem[addr] <= wr_qty;
    rd_price <= price_mem[addr];
    rd_qty   <= qty_mem[addr];
    rd_arr   <= arr_mem[addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      valid           <= '0;
      arrival_counter <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (emit) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_buy          <= order.side_is_buy;
            sym_in          <= order.symbol_index;
            limit           <= order.limit_price;
            left            <= order.order_qty;
            stamp           <= arrival_counter;
            arrival_counter <= arrival_counter + 1'b1;
            opp_base        <= order.side_is_buy ? base_sell : base_buy;
            own_base        <= order.side_is_buy ? base_buy : base_sell;
            slot            <= '0;
            found           <= 1'b0;
            state           <= (order.order_qty == '0) ? S_CLOSE : S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (eligible && better) begin
            found      <= 1'b1;
            best_slot  <= slot;
            best_price <= rd_price;
            best_arr   <= rd_arr;
            best_qty   <= rd_qty;
          end
          if (slot == LAST_SLOT) begin
            slot  <= '0;
            state <= (found || eligible) ? S_FILL : S_REST;
          end else begin
            slot  <= slot + 1'b1;
            state <= S_RD;
          end
        end
        S_FILL: begin
          if (out_free) begin
            if (rest_qty == '0) valid[addr] <= 1'b0;
            left                <= left_next;
            result.event_kind   <= KIND_FILL;
            result.trade_symbol <= sym_in;
            result.trade_price  <= best_price;
            result.trade_qty    <= fill;
            result.left_qty     <= left_next;
            result.last_of_run  <= 1'b0;
            found               <= 1'b0;
            slot                <= '0;
            state               <= (left_next == '0) ? S_CLOSE : S_RD;
          end
        end
        S_REST: begin
          if (out_free) begin
            if (free_hit || slot == LAST_SLOT) begin
              if (free_hit) valid[addr] <= 1'b1;
              result.event_kind   <= free_hit ? KIND_REST : KIND_DROP;
              result.trade_symbol <= sym_in;
              result.trade_price  <= '0;
              result.trade_qty    <= '0;
              result.left_qty     <= left;
              result.last_of_run  <= 1'b1;
              state               <= S_IDLE;
            end else begin
              slot <= slot + 1'b1;
            end
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            result.event_kind   <= KIND_DONE;
            result.trade_symbol <= sym_in;
            result.trade_price  <= '0;
            result.trade_qty    <= '0;
            result.left_qty     <= '0;
            result.last_of_run  <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ptom_checker.sv =====
// ----------------------------------------------------------------------------
// ptom_checker
// Port-level checks of the order matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptom_checker (
  input logic              clk,
  input logic              rst,
  input logic              order_valid,
  input logic              order_ready,
  input ptom_pkg::order_t  order,
  input logic              result_valid,
  input logic              result_ready,
  input ptom_pkg::result_t result
);
  import ptom_pkg::*;

  // one order in flight: ready drops after a request
  `PTOM_ASSERT(a_busy_after_req, clk, rst, order_valid && order_ready |=> !order_ready, "ready held after request")

  // intermediate results are real fills
  `PTOM_ASSERT(a_mid_is_fill, clk, rst, result_valid && !result.last_of_run |-> result.event_kind == KIND_FILL && result.trade_qty != '0, "non-closing result is not a fill")

  // closing result carries no trade
  `PTOM_ASSERT(a_close_no_trade, clk, rst, result_valid && result.last_of_run |-> result.event_kind != KIND_FILL && result.trade_qty == '0 && result.trade_price == '0, "closing result carries a trade")

  // fully filled closes with nothing left
  `PTOM_ASSERT(a_done_empty, clk, rst, result_valid && result.event_kind == KIND_DONE |-> result.left_qty == '0, "done with quantity left")

endmodule

bind price_time_order_matcher ptom_checker u_ptom_checker (.*);
